// ===== rtl/core/idel_pkg.sv =====
// Shared command and status codes for the indexed double-ended list.
package idel_pkg;

	typedef logic [2:0] cmd_t;
	typedef logic [1:0] status_t;

	localparam cmd_t CMD_PUSH_FRONT = 3'd0;
	localparam cmd_t CMD_PUSH_BACK  = 3'd1;
	localparam cmd_t CMD_POP_FRONT  = 3'd2;
	localparam cmd_t CMD_POP_BACK   = 3'd3;
	localparam cmd_t CMD_INSERT     = 3'd4;
	localparam cmd_t CMD_DELETE     = 3'd5;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;
	localparam status_t ST_RANGE = 2'd3;

	localparam int CMD_W   = 3;
	localparam int POS_W   = 4;
	localparam int PORT_W  = 32;
	localparam int COUNT_W = 5;

endpackage

// ===== rtl/core/indexed_double_ended_list.sv =====
// Indexed double-ended list: ordered cells with push, pop, insert and delete by index.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-----------------------------------
//  in      | in_valid  | in_stall  | command, position, data_in
//  out     | out_valid | out_stall | data_out, status, entry_count
//
// One command per cycle sustained unless out_stall holds the result. A transaction
// is captured in the input register, then per-cell compare and shift logic
// updates the cells (on an OK status) and the count and loads the result register.
// Every cell looks only at its own index and its two neighbors, so no cell
// update depends on another one in the same cycle.
// arst_n clears the valid bits and the count; cell contents are not reset
// and are only read below the count. in_stall rises only while a
// transaction waits in the input register behind a stalled result.
module indexed_double_ended_list
	import idel_pkg::*;
#(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [CMD_W-1:0]    command,
	input  logic [POS_W-1:0]    position,
	input  logic [PORT_W-1:0]   data_in,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [PORT_W-1:0]   data_out,
	output logic [1:0]          status,
	output logic [COUNT_W-1:0]  entry_count
);

	localparam int CW = $clog2(CAPACITY + 1);           // count width
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1; // compare width
	localparam int MW = (DATA_WIDTH < PORT_W) ? DATA_WIDTH : PORT_W;

	// input stage
	logic                  valid_s1;
	cmd_t                  cmd_s1;
	logic [POS_W-1:0]      pos_s1;
	logic [PORT_W-1:0]     data_s1;

	// state
	logic [DATA_WIDTH-1:0] cells_q [CAPACITY];
	logic [DATA_WIDTH-1:0] cells_nxt [CAPACITY];
	logic [CW-1:0]         count_q;

	// result register
	logic                  out_valid_q;
	logic [PORT_W-1:0]     data_out_q;
	status_t               status_q;
	logic [COUNT_W-1:0]    entry_count_q;

	logic                  advance;
	logic                  fire;
	logic [XW-1:0]         cnt_x;
	logic [XW-1:0]         pos_x;
	logic [XW-1:0]         pos1_x;
	logic                  is_full;
	logic                  is_empty;
	logic                  pos_bad;
	logic                  ok;
	status_t               st;
	logic [CW-1:0]         count_nxt;
	logic [AW-1:0]         rd_idx;
	logic [DATA_WIDTH-1:0] rd_word;
	logic [DATA_WIDTH-1:0] din_ext;
	logic [PORT_W-1:0]     removed;
	logic                  removes;

	// result register frees up when empty or being taken
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign fire     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1  <= command;
			pos_s1  <= position;
			data_s1 <= data_in;
		end
	end

	// decode
	assign cnt_x    = XW'(count_q);
	assign pos_x    = XW'(pos_s1);
	assign pos1_x   = pos_x + XW'(1);
	assign is_full  = cnt_x >= XW'(CAPACITY);
	assign is_empty = count_q == '0;
	assign pos_bad  = pos_x >= cnt_x;

	always_comb begin
		st = ST_OK;
		case (cmd_s1)
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				if (is_full) st = ST_FULL;
			end
			CMD_POP_FRONT, CMD_POP_BACK: begin
				if (is_empty) st = ST_EMPTY;
			end
			CMD_INSERT: begin
				if (pos_bad) st = ST_RANGE;
				else if (is_full) st = ST_FULL;
			end
			CMD_DELETE: begin
				if (pos_bad) st = ST_RANGE;
			end
			default: st = ST_OK;
		endcase
	end

	assign ok = st == ST_OK;

	always_comb begin
		count_nxt = count_q;
		removes   = 1'b0;
		case (cmd_s1)
			CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
				if (ok) count_nxt = count_q + CW'(1);
			end
			CMD_POP_FRONT, CMD_POP_BACK, CMD_DELETE: begin
				if (ok) begin
					count_nxt = count_q - CW'(1);
					removes   = 1'b1;
				end
			end
			default: count_nxt = count_q;
		endcase
	end

	// word leaving the list
	always_comb begin
		case (cmd_s1)
			CMD_POP_BACK: rd_idx = AW'(count_q - CW'(1));
			CMD_DELETE:   rd_idx = AW'(pos_s1);
			default:      rd_idx = '0;
		endcase
	end

	assign rd_word = cells_q[rd_idx];

	always_comb begin
		removed = '0;
		if (removes) removed[MW-1:0] = rd_word[MW-1:0];
	end

	always_comb begin
		din_ext = '0;
		din_ext[MW-1:0] = data_s1[MW-1:0];
	end

	// per-cell next value: each cell compares its own index
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_w;
		logic [DATA_WIDTH-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = cells_q[i];
		end else begin : g_mid_l
			assign left_w = cells_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = cells_q[i];
		end else begin : g_mid_r
			assign right_w = cells_q[i+1];
		end

		always_comb begin
			cells_nxt[i] = cells_q[i];
			case (cmd_s1)
				CMD_PUSH_FRONT: cells_nxt[i] = (i == 0) ? din_ext : left_w;
				CMD_PUSH_BACK: begin
					if (cnt_x == XW'(i)) cells_nxt[i] = din_ext;
				end
				CMD_POP_FRONT: cells_nxt[i] = right_w;
				CMD_INSERT: begin
					if (pos1_x == XW'(i)) cells_nxt[i] = din_ext;
					else if (pos1_x < XW'(i)) cells_nxt[i] = left_w;
				end
				CMD_DELETE: begin
					if (pos_x <= XW'(i)) cells_nxt[i] = right_w;
				end
				default: cells_nxt[i] = cells_q[i];
			endcase
		end

		always_ff @(posedge clk) begin
			if (fire && ok) begin
				cells_q[i] <= cells_nxt[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) count_q <= count_nxt;
			if (advance) out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			data_out_q    <= removed;
			status_q      <= st;
			entry_count_q <= COUNT_W'(count_nxt);
		end
	end

	assign out_valid   = out_valid_q;
	assign data_out    = data_out_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;

endmodule
